// ----- design/mtb_pkg.sv -----
// Shared constants, types and helpers of the matrix transpose buffer.
// No dependencies; every module names these by mtb_pkg:: scope.
`timescale 1ns / 1ps
`default_nettype none
package mtb_pkg;

  localparam int unsigned MAX_ROWS    = 8;
  localparam int unsigned MAX_COLS    = 8;
  localparam int unsigned DIM_W       = 4;
  localparam int unsigned DATA_W      = 64;
  localparam int unsigned STORE_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned ROW_IDX_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned COL_IDX_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned MEM_AW      = ADDR_W + 1;  // one bank bit on top
  localparam int unsigned CNT_W       = ADDR_W + 1;  // can hold STORE_DEPTH itself

  // register indexes on the APB port
  localparam logic REG_ROW_COUNT = 1'b0;
  localparam logic REG_COL_COUNT = 1'b1;

  // memory write port, front -> back
  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [DATA_W-1:0] low;
    logic [DATA_W-1:0] high;
  } mtb_wr_t;

  // drain command for one full matrix
  typedef struct packed {
    logic             bank;
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
  } mtb_cmd_t;

  // back tells front that a bank has been fully read
  typedef struct packed {
    logic valid;
    logic bank;
  } mtb_done_t;

  // one staged output word
  typedef struct packed {
    logic [DATA_W-1:0] low;
    logic [DATA_W-1:0] high;
    logic              last;
  } mtb_out_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } mtb_state_e;

  // out-of-range dimension: 0 reads as 1, above max reads as max
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W:0]   maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if ({1'b0, v} > maxv) begin
      r = maxv[DIM_W-1:0];
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- design/matrix_transpose_buffer_unit.sv -----
// Top level of the matrix transpose buffer (corner turn): APB registers,
// fill front, command queue and drain back. Depends on mtb_pkg, mtb_front,
// mtb_cmd_fifo and mtb_back.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+-------------------------------
//   in       | sink      | in_valid_i/in_ready_o | elem_low_i, elem_high_i
//   out      | source    | out_valid_o/out_ready_i| out_low_o, out_high_o, out_last_o
//   apb      | slave     | psel/penable/pready   | paddr, pwrite, pwdata, prdata
//
// Cycles: one word is stored per cycle while in_ready_o is high. A complete
// matrix of R*C words drains at one word per cycle while out_ready_i is high,
// after startup through queue pop, store read and output buffer. The store
// has two banks, so the next matrix fills while the previous one drains; the
// fill stalls only when it reaches a bank the drain has not finished reading.
// Reset: asynchronous, active low; dimensions come up as 1 by 1, fill
// count at zero. Store contents are not cleared and need no clearing pass.
// Stalls: out_ready_i low holds the two-word output buffer, which throttles
// store reads; the command queue lets the front keep filling meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module matrix_transpose_buffer_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // input words
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [mtb_pkg::DATA_W-1:0]  elem_low_i,
  input  wire logic [mtb_pkg::DATA_W-1:0]  elem_high_i,
  // output words
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [mtb_pkg::DATA_W-1:0]       out_low_o,
  output logic [mtb_pkg::DATA_W-1:0]       out_high_o,
  output logic                             out_last_o,
  // configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  logic [mtb_pkg::DIM_W-1:0] row_count_q, col_count_q;
  logic                      cfg_wr;
  logic                      reg_sel;

  mtb_pkg::mtb_wr_t   wr;
  mtb_pkg::mtb_cmd_t  push_cmd, pop_cmd;
  mtb_pkg::mtb_done_t done;
  logic               push, fifo_full, cmd_valid, cmd_pop;

  // registers at byte offsets 0 (row_count) and 4 (col_count)
  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= mtb_pkg::DIM_W'(1);
      col_count_q <= mtb_pkg::DIM_W'(1);
    end else if (cfg_wr) begin
      case (reg_sel)
        mtb_pkg::REG_ROW_COUNT: row_count_q <= pwdata[mtb_pkg::DIM_W-1:0];
        mtb_pkg::REG_COL_COUNT: col_count_q <= pwdata[mtb_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      mtb_pkg::REG_ROW_COUNT: prdata = 32'(row_count_q);
      mtb_pkg::REG_COL_COUNT: prdata = 32'(col_count_q);
      default:                prdata = '0;
    endcase
  end

  // any register write drops a partly filled matrix
  mtb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .elem_low_i  (elem_low_i),
    .elem_high_i (elem_high_i),
    .row_count_i (row_count_q),
    .col_count_i (col_count_q),
    .cfg_clear_i (cfg_wr),
    .done_i      (done),
    .fifo_full_i (fifo_full),
    .wr_o        (wr),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  mtb_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (fifo_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .data_o  (pop_cmd)
  );

  mtb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (pop_cmd),
    .cmd_pop_o   (cmd_pop),
    .done_o      (done),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_low_o   (out_low_o),
    .out_high_o  (out_high_o),
    .out_last_o  (out_last_o)
  );

endmodule
`default_nettype wire

// ----- design/mtb_cmd_fifo.sv -----
// Two-entry queue of drain commands between the fill front and the drain back.
// Depends on mtb_pkg for the command type.
`timescale 1ns / 1ps
`default_nettype none
module mtb_cmd_fifo (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire mtb_pkg::mtb_cmd_t data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic                  valid_o,
  output mtb_pkg::mtb_cmd_t     data_o
);

  mtb_pkg::mtb_cmd_t mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q ^ do_push;
    rptr_d = rptr_q ^ do_pop;
    cnt_d  = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ----- design/mtb_front.sv -----
// Fill side: accepts words, writes them column-major into the current bank,
// and queues a drain command when a matrix is complete. Depends on mtb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mtb_front (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [mtb_pkg::DATA_W-1:0]  elem_low_i,
  input  wire logic [mtb_pkg::DATA_W-1:0]  elem_high_i,
  input  wire logic [mtb_pkg::DIM_W-1:0]   row_count_i,
  input  wire logic [mtb_pkg::DIM_W-1:0]   col_count_i,
  input  wire logic                        cfg_clear_i,
  input  wire mtb_pkg::mtb_done_t          done_i,
  input  wire logic                        fifo_full_i,
  output mtb_pkg::mtb_wr_t                 wr_o,
  output logic                             push_o,
  output mtb_pkg::mtb_cmd_t                cmd_o
);

  logic [mtb_pkg::DIM_W-1:0]  rows, cols;
  logic [mtb_pkg::CNT_W-1:0]  total, fill_inc;
  logic [mtb_pkg::ADDR_W-1:0] fill_q, fill_d;
  logic                       bank_q, bank_d;
  logic [1:0]                 busy_q, busy_d;
  logic                       accept, complete;

  always_comb begin
    rows  = mtb_pkg::clamp_dim(row_count_i, (mtb_pkg::DIM_W + 1)'(mtb_pkg::MAX_ROWS));
    cols  = mtb_pkg::clamp_dim(col_count_i, (mtb_pkg::DIM_W + 1)'(mtb_pkg::MAX_COLS));
    total = mtb_pkg::CNT_W'(rows) * mtb_pkg::CNT_W'(cols);
  end

  // a bank is writable only once the back has read all of it
  assign in_ready_o = !busy_q[bank_q] && !fifo_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign fill_inc   = {1'b0, fill_q} + mtb_pkg::CNT_W'(1);
  assign complete   = accept && (fill_inc >= total);

  always_comb begin
    wr_o.en   = accept;
    wr_o.addr = {bank_q, fill_q};
    wr_o.low  = elem_low_i;
    wr_o.high = elem_high_i;
    push_o    = complete;
    cmd_o.bank = bank_q;
    cmd_o.rows = rows;
    cmd_o.cols = cols;
  end

  always_comb begin
    fill_d = fill_q;
    bank_d = bank_q;
    busy_d = busy_q;
    if (done_i.valid) begin
      busy_d[done_i.bank] = 1'b0;
    end
    if (complete) begin
      fill_d         = '0;
      bank_d         = ~bank_q;
      busy_d[bank_q] = 1'b1;
    end else if (accept) begin
      fill_d = fill_inc[mtb_pkg::ADDR_W-1:0];
    end
    if (cfg_clear_i) begin
      fill_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      bank_q <= 1'b0;
      busy_q <= 2'b00;
    end else begin
      fill_q <= fill_d;
      bank_q <= bank_d;
      busy_q <= busy_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/mtb_back.sv -----
// Drain side: holds the two-bank word store, reads a full matrix row by row
// and stages results in a two-word output buffer. Depends on mtb_pkg.
`timescale 1ns / 1ps
`default_nettype none
module mtb_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire mtb_pkg::mtb_wr_t            wr_i,
  input  wire logic                        cmd_valid_i,
  input  wire mtb_pkg::mtb_cmd_t           cmd_i,
  output logic                             cmd_pop_o,
  output mtb_pkg::mtb_done_t               done_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [mtb_pkg::DATA_W-1:0]       out_low_o,
  output logic [mtb_pkg::DATA_W-1:0]       out_high_o,
  output logic                             out_last_o
);

  localparam int unsigned MEM_DEPTH = 2 * mtb_pkg::STORE_DEPTH;

  logic [2*mtb_pkg::DATA_W-1:0] mem [MEM_DEPTH];

  mtb_pkg::mtb_state_e             state_q, state_d;
  logic                            bank_q, bank_d;
  logic [mtb_pkg::DIM_W-1:0]       rows_q, rows_d, cols_q, cols_d;
  logic [mtb_pkg::ROW_IDX_W-1:0]   i_q, i_d;
  logic [mtb_pkg::COL_IDX_W-1:0]   j_q, j_d;
  logic [mtb_pkg::ADDR_W-1:0]      addr_q, addr_d;

  logic                            rd_q, rd_last_q;
  logic [2*mtb_pkg::DATA_W-1:0]    rd_data_q;

  mtb_pkg::mtb_out_t               obuf_q [2];
  logic                            owptr_q, orptr_q;
  logic [1:0]                      ocnt_q, ocnt_d;

  logic issue, issue_last, row_end, pop;

  // store writes from the front
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= {wr_i.high, wr_i.low};
    end
  end

  assign pop      = out_valid_o && out_ready_i;
  assign row_end  = (mtb_pkg::DIM_W'(j_q) == cols_q - mtb_pkg::DIM_W'(1));
  assign issue_last = row_end && (mtb_pkg::DIM_W'(i_q) == rows_q - mtb_pkg::DIM_W'(1));
  // keep reads in flight plus buffered words within the two buffer slots
  assign issue = (state_q == mtb_pkg::ST_DRAIN) &&
                 (({1'b0, ocnt_q} + {2'b00, rd_q}) < (3'd2 + {2'b00, pop}));

  assign done_o.valid = issue && issue_last;
  assign done_o.bank  = bank_q;
  assign cmd_pop_o    = (state_q == mtb_pkg::ST_IDLE) && cmd_valid_i;

  always_comb begin
    state_d = state_q;
    bank_d  = bank_q;
    rows_d  = rows_q;
    cols_d  = cols_q;
    i_d     = i_q;
    j_d     = j_q;
    addr_d  = addr_q;
    case (state_q)
      mtb_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = mtb_pkg::ST_DRAIN;
          bank_d  = cmd_i.bank;
          rows_d  = cmd_i.rows;
          cols_d  = cmd_i.cols;
          i_d     = '0;
          j_d     = '0;
          addr_d  = '0;
        end
      end
      mtb_pkg::ST_DRAIN: begin
        if (issue) begin
          if (issue_last) begin
            state_d = mtb_pkg::ST_IDLE;
          end else if (row_end) begin
            // next output row: element (i+1, 0) sits at address i+1
            i_d    = i_q + mtb_pkg::ROW_IDX_W'(1);
            j_d    = '0;
            addr_d = mtb_pkg::ADDR_W'(i_q) + mtb_pkg::ADDR_W'(1);
          end else begin
            j_d    = j_q + mtb_pkg::COL_IDX_W'(1);
            addr_d = addr_q + mtb_pkg::ADDR_W'(rows_q);
          end
        end
      end
      default: begin
        state_d = mtb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mtb_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bank_q <= bank_d;
    rows_q <= rows_d;
    cols_q <= cols_d;
    i_q    <= i_d;
    j_q    <= j_d;
    addr_q <= addr_d;
  end

  // registered store read
  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_data_q <= mem[{bank_q, addr_q}];
      rd_last_q <= issue_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0;
    end else begin
      rd_q <= issue;
    end
  end

  // output buffer
  assign out_valid_o = (ocnt_q != 2'd0);
  assign out_low_o   = obuf_q[orptr_q].low;
  assign out_high_o  = obuf_q[orptr_q].high;
  assign out_last_o  = obuf_q[orptr_q].last;
  assign ocnt_d      = ocnt_q + {1'b0, rd_q} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owptr_q <= 1'b0;
      orptr_q <= 1'b0;
      ocnt_q  <= 2'd0;
    end else begin
      owptr_q <= owptr_q ^ rd_q;
      orptr_q <= orptr_q ^ pop;
      ocnt_q  <= ocnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_q) begin
      obuf_q[owptr_q].low  <= rd_data_q[mtb_pkg::DATA_W-1:0];
      obuf_q[owptr_q].high <= rd_data_q[2*mtb_pkg::DATA_W-1:mtb_pkg::DATA_W];
      obuf_q[owptr_q].last <= rd_last_q;
    end
  end

endmodule
`default_nettype wire
